// File: sv/trlru_pkg.sv
`default_nettype none

package trlru_pkg;

    // Width of a frame index as it travels on the ports and in each cell.
    localparam int FRAME_W = 4;

    // Request codes.
    localparam logic [1:0] REQ_ACCESS = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_VICTIM = 2'd2;

    // One input transfer.
    typedef struct packed {
        logic [1:0]         req_type;
        logic [FRAME_W-1:0] frame;
    } req_t;

    // One result transfer.
    typedef struct packed {
        logic [FRAME_W-1:0] victim_frame;
        logic               order_empty;
    } rsp_t;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_TOUCH = 2'd1,
        CELL_POP   = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [FRAME_W-1:0] frame;
    } cell_cmd_t;

    // Contents of one cell as seen by its neighbors.
    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] id;
    } cell_link_t;

endpackage

`default_nettype wire

// File: sv/trlru_cell.sv
`default_nettype none

module trlru_cell
    import trlru_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_cmd_t  cmd,
    input  wire logic       below_valid,
    input  wire logic       hit_in,
    input  wire cell_link_t above,
    output logic            hit_out,
    output cell_link_t      state
);

    logic               valid_reg;
    logic               valid_next;
    logic [FRAME_W-1:0] id_reg;
    logic [FRAME_W-1:0] id_next;
    logic               self_match;
    logic               shift;

    // A hit at or below this cell means this cell closes the gap by one.
    assign self_match = valid_reg && (id_reg == cmd.frame);
    assign shift      = hit_in || self_match;
    assign hit_out    = shift;

    assign state.valid = valid_reg;
    assign state.id    = id_reg;

    // Next contents: take the newer neighbor, load the touched frame, or hold.
    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        case (cmd.op)
            CELL_TOUCH:
            begin
                if (shift)
                begin
                    if (above.valid)
                    begin
                        valid_next = 1'b1;
                        id_next    = above.id;
                    end
                    else if (valid_reg)
                    begin
                        id_next = cmd.frame;
                    end
                    else
                    begin
                        valid_next = 1'b0;
                    end
                end
                else if (!valid_reg && below_valid)
                begin
                    valid_next = 1'b1;
                    id_next    = cmd.frame;
                end
            end
            CELL_POP:
            begin
                valid_next = above.valid;
                id_next    = above.id;
            end
            default:
            begin
                valid_next = valid_reg;
                id_next    = id_reg;
            end
        endcase
    end

    // The valid bit is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // The frame index is payload and needs no reset.
    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

endmodule

`default_nettype wire

// File: sv/true_lru_replacement.sv
// A victim result appears on result, with done high, in the cycle after its transfer.
// Throughput: one request per cycle; busy is always low and the receiver cannot stall.
// Each request is settled by a ripple of the hit flag along the cell row.
// Reset (rst_n, asynchronous, active low) empties the order; no clearing pass is needed.
`default_nettype none

module true_lru_replacement
    import trlru_pkg::*;
#(
    parameter int FRAMES = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t req,
    output logic      done,
    output rsp_t      result
);

    cell_cmd_t  cmd;
    cell_link_t links [FRAMES+1];
    logic       hits  [FRAMES+1];
    logic       frame_ok;
    logic       take;
    logic       done_reg;
    logic       done_next;
    rsp_t       result_reg;
    rsp_t       result_next;

    assign busy     = 1'b0;
    assign take     = start && !busy;
    assign frame_ok = (32'(req.frame) < 32'(FRAMES));

    // Decode the request into the operation shared by all cells.
    always_comb
    begin
        cmd.frame = req.frame;
        cmd.op    = CELL_HOLD;
        if (take)
        begin
            case (req.req_type)
                REQ_ACCESS, REQ_INSERT:
                begin
                    if (frame_ok)
                    begin
                        cmd.op = CELL_TOUCH;
                    end
                end
                REQ_VICTIM:
                begin
                    cmd.op = CELL_POP;
                end
                default:
                begin
                    cmd.op = CELL_HOLD;
                end
            endcase
        end
    end

    // Cell 0 holds the least recent frame; newer frames sit at higher cells.
    assign links[FRAMES] = '0;
    assign hits[0]       = 1'b0;

    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        logic below_valid;
        if (i == 0)
        begin : g_first
            assign below_valid = 1'b1;
        end
        else
        begin : g_rest
            assign below_valid = links[i-1].valid;
        end

        trlru_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .below_valid (below_valid),
            .hit_in      (hits[i]),
            .above       (links[i+1]),
            .hit_out     (hits[i+1]),
            .state       (links[i])
        );
    end

    // A victim transfer reports the oldest cell before it shifts out.
    always_comb
    begin
        done_next                = take && (req.req_type == REQ_VICTIM);
        result_next.order_empty  = !links[0].valid;
        result_next.victim_frame = links[0].valid ? links[0].id : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import trlru_pkg::*;

    // Request code that the block ignores; the package names only the three real ones.
    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int FRAME_COUNT = 16;
    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req = '0;
    logic busy;
    logic done;
    rsp_t result;

    // Recency order of resident frames, oldest at the front.
    logic [FRAME_W-1:0] recency_order[$];
    // Victim results still owed by the block.
    rsp_t victim_expect_q[$];
    int error_count = 0;
    int quiet_cycles = 0;
    bit idle_on = 1'b0;

    true_lru_replacement #(
        .FRAMES(FRAME_COUNT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .done(done),
        .result(result)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one accepted request to the recency order and queue any victim it owes.
    function automatic void apply_request(req_t r);
        rsp_t rsp;
        int pos;
        pos = -1;
        case (r.req_type)
            REQ_ACCESS, REQ_INSERT:
            begin
                if (r.frame < FRAME_COUNT)
                begin
                    // A resident frame is unlinked first, so access and insert coincide.
                    for (int i = 0; i < recency_order.size(); i++)
                        if (recency_order[i] == r.frame)
                            pos = i;
                    if (pos >= 0)
                        recency_order.delete(pos);
                    recency_order.push_back(r.frame);
                end
            end
            REQ_VICTIM:
            begin
                if (recency_order.size() == 0)
                begin
                    rsp.victim_frame = '0;
                    rsp.order_empty = 1'b1;
                end
                else
                begin
                    rsp.victim_frame = recency_order.pop_front();
                    rsp.order_empty = 1'b0;
                end
                victim_expect_q.push_back(rsp);
            end
            default:
            begin
            end
        endcase
    endfunction

    // Check each result strobe against the oldest owed victim, then take in new transfers.
    always @(posedge clk)
    begin : check_results
        rsp_t owed;
        if (rst_n)
        begin
            if (done)
            begin
                if (victim_expect_q.size() == 0)
                begin
                    $error("result with none owed: victim_frame=%0d order_empty=%0b",
                           result.victim_frame, result.order_empty);
                    error_count++;
                end
                else
                begin
                    owed = victim_expect_q.pop_front();
                    if (result.victim_frame !== owed.victim_frame)
                    begin
                        $error("victim_frame: expected %0d, got %0d",
                               owed.victim_frame, result.victim_frame);
                        error_count++;
                    end
                    if (result.order_empty !== owed.order_empty)
                    begin
                        $error("order_empty: expected %0b, got %0b",
                               owed.order_empty, result.order_empty);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
                apply_request(req);
        end
    end

    // Watchdog: end the run if no transfer and no result happen for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[true_lru_replacement] ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one request, with random idle cycles ahead of it when idling is enabled.
    task automatic send_request(input logic [1:0] kind, input logic [FRAME_W-1:0] fr);
        req_t r;
        r.req_type = kind;
        r.frame = fr;
        if (idle_on)
        begin
            while ($urandom_range(0, 99) < 10)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stop sending and wait until every owed victim has arrived.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (victim_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Hand-picked sequence covering the empty order and both role swaps.
    task automatic test_directed();
        idle_on = 1'b0;
        send_request(REQ_VICTIM, 4'd9);      // victim from an empty order
        send_request(REQ_ACCESS, 4'd0);      // access of a non-resident frame
        send_request(REQ_INSERT, 4'd15);
        send_request(REQ_ACCESS, 4'd15);     // access of the newest frame
        send_request(REQ_INSERT, 4'd0);      // insert of a resident frame
        send_request(REQ_NONE, 4'd5);
        send_request(REQ_ACCESS, 4'd7);
        send_request(REQ_INSERT, 4'd8);
        send_request(REQ_VICTIM, 4'd0);
        send_request(REQ_VICTIM, 4'd15);
        send_request(REQ_ACCESS, 4'd8);      // access of the newest frame
        send_request(REQ_VICTIM, 4'd3);
        send_request(REQ_VICTIM, 4'd12);
        send_request(REQ_VICTIM, 4'd15);     // drained again
        send_request(REQ_INSERT, 4'd3);
        send_request(REQ_VICTIM, 4'd0);
        send_request(REQ_VICTIM, 4'd0);
        send_request(REQ_NONE, 4'd15);
        send_request(REQ_ACCESS, 4'd10);
        send_request(REQ_ACCESS, 4'd10);     // access of the only resident frame
        send_request(REQ_INSERT, 4'd10);
        send_request(REQ_VICTIM, 4'd6);
        send_request(REQ_VICTIM, 4'd6);
        wait_for_results();
    endtask

    // Fill every frame in random order, touch a few, then evict past empty.
    task automatic test_fill_and_drain(input int rounds);
        logic [FRAME_W-1:0] perm[FRAME_COUNT];
        logic [FRAME_W-1:0] swap;
        int j;
        idle_on = 1'b1;
        for (int r = 0; r < rounds; r++)
        begin
            for (int i = 0; i < FRAME_COUNT; i++)
                perm[i] = FRAME_W'(i);
            for (int i = FRAME_COUNT - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                swap = perm[i];
                perm[i] = perm[j];
                perm[j] = swap;
            end
            for (int i = 0; i < FRAME_COUNT; i++)
                send_request(($urandom_range(0, 1) != 0) ? REQ_INSERT : REQ_ACCESS, perm[i]);
            repeat (8)
                send_request(($urandom_range(0, 1) != 0) ? REQ_INSERT : REQ_ACCESS,
                             FRAME_W'($urandom_range(0, FRAME_COUNT - 1)));
            repeat (FRAME_COUNT + 1)
                send_request(REQ_VICTIM, FRAME_W'($urandom()));
        end
    endtask

    // Random mix of accesses, inserts, victims and ignored codes over a frame pool that narrows at times.
    task automatic test_random_traffic(input int count, input bit with_idle);
        int kind_pick;
        int frame_max;
        int sent;
        logic [FRAME_W-1:0] fr;
        idle_on = with_idle;
        sent = 0;
        frame_max = FRAME_COUNT - 1;
        while (sent < count)
        begin
            if (sent % 64 == 0)
                frame_max = (1 << $urandom_range(2, FRAME_W)) - 1;
            fr = FRAME_W'($urandom_range(0, frame_max));
            kind_pick = $urandom_range(0, 99);
            if (kind_pick < 5)
                send_request(REQ_NONE, FRAME_W'($urandom()));
            else
            begin
                if (kind_pick < 35)
                    send_request(REQ_VICTIM, FRAME_W'($urandom()));
                else if (kind_pick < 65)
                    send_request(REQ_ACCESS, fr);
                else
                    send_request(REQ_INSERT, fr);
                sent++;
            end
        end
    endtask

    // Test sequence.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_and_drain(4);
        test_random_traffic(400, 1'b1);
        wait_for_results();
        test_random_traffic(300, 1'b0);
        wait_for_results();
        test_random_traffic(250, 1'b1);
        test_fill_and_drain(2);
        wait_for_results();

        if (error_count == 0)
            $display("[true_lru_replacement] OK");
        else
            $display("[true_lru_replacement] ERROR");
        $finish;
    end

endmodule
